>>> rtl/mfmscan_pkg.sv
// mfmscan_pkg: shared types, constants and crc helper of the mfm track sector scanner
// no dependencies
package mfmscan_pkg;

	localparam int MAX_SECTORS_DEF      = 32;
	localparam int TRACK_BYTES_MAX_DEF  = 8192;
	localparam int DATA_MARK_WINDOW_DEF = 43;

	localparam int POS_W     = 14;
	localparam int TLEN_W    = 14;
	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0]  MARK_A1   = 8'hA1;
	localparam logic [7:0]  MARK_ID   = 8'hFE;
	localparam logic [7:0]  MARK_DEL  = 8'hF8;
	localparam logic [7:0]  MARK_DATA = 8'hFB;
	localparam logic [15:0] CRC_SEED  = 16'hCDB4;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam int          GAP_BYTES = 8;
	localparam logic [10:0] BASE_LEN  = 11'd128;
	localparam logic [13:0] TLEN_RESET = 14'd6250;
	localparam logic [2:0]  REG_TRACK_LENGTH = 3'd0;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_WINDOW,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic             rst;
		logic [7:0]       b;
		logic             mk;
		logic             pr;
		logic             prev_a1;
		logic             idmark;
		logic [POS_W-1:0] pos;
	} item_t;

	typedef struct packed {
		logic        over;
		logic        prot;
		logic [10:0] dlen;
		logic [12:0] dpos;
		logic        dok;
		logic        dat;
		logic        idok;
		logic [7:0]  size;
		logic [7:0]  sec;
		logic [7:0]  head;
		logic [7:0]  cyl;
		logic [4:0]  slot;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

endpackage

>>> rtl/mfm_track_sector_scanner_top.sv
// channel   | dir | payload
// s_axis    | in  | tdata: track_byte; tuser: track_start, mark_clock, protect_bit
// m_axis    | out | tdata: one sector result per transaction
// apb       | in  | track_length at address 0
// one byte per cycle while the queue is not full; a byte passes front, 4-entry queue and back in that order
// a sector result is registered and shown in the cycle after its closing byte is taken by the back end
// reset clears position, sector count, scan state and queue; track_length to 6250
// output stall holds the back end; the queue then fills and drops s_axis_tready
// mfm_track_sector_scanner_top: top level, config register and wiring
// depends on mfmscan_pkg, mfmscan_front, mfmscan_fifo, mfmscan_back
module mfm_track_sector_scanner_top #(
	parameter int MAX_SECTORS      = mfmscan_pkg::MAX_SECTORS_DEF,
	parameter int TRACK_BYTES_MAX  = mfmscan_pkg::TRACK_BYTES_MAX_DEF,
	parameter int DATA_MARK_WINDOW = mfmscan_pkg::DATA_MARK_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] track_byte
	input  logic [2:0]  s_axis_tuser,   // [0] track_start, [1] mark_clock, [2] protect_bit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] sector_slot, [12:5] cylinder_id, [20:13] head_id, [28:21] sector_id,
	// [36:29] size_code, [37] id_crc_good, [38] data_present, [39] data_crc_good,
	// [52:40] data_position, [63:53] data_length, [64] protected_data,
	// [65] too_many_sectors, [71:66] zero
	output logic [71:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mfmscan_pkg::*;

	logic [TLEN_W-1:0] tlen_q;
	logic [POS_W:0]    len;
	logic              full, empty, pop, in_fire, out_valid;
	item_t             f_item, q_item;
	result_t           res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TRACK_LENGTH[2]) ? 32'(tlen_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= TLEN_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TRACK_LENGTH[2])) begin
			tlen_q <= pwdata[TLEN_W-1:0];
		end
	end

	assign len = ((POS_W+1)'(tlen_q) > (POS_W+1)'(TRACK_BYTES_MAX)) ?
		(POS_W+1)'(TRACK_BYTES_MAX) : (POS_W+1)'(tlen_q);

	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && !full;

	mfmscan_front #(
		.TRACK_BYTES_MAX(TRACK_BYTES_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.track_start(s_axis_tuser[0]),
		.track_byte (s_axis_tdata),
		.mark_clock (s_axis_tuser[1]),
		.protect_bit(s_axis_tuser[2]),
		.len        (len),
		.item       (f_item)
	);

	mfmscan_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_fire),
		.wr_item(f_item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_item(q_item)
	);

	mfmscan_back #(
		.MAX_SECTORS     (MAX_SECTORS),
		.DATA_MARK_WINDOW(DATA_MARK_WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.it       (q_item),
		.pop      (pop),
		.len      (len),
		.out_valid(out_valid),
		.out_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {6'd0, res.over, res.prot, res.dlen, res.dpos, res.dok,
		res.dat, res.idok, res.size, res.sec, res.head, res.cyl, res.slot};

endmodule

>>> rtl/mfmscan_front.sv
// mfmscan_front: takes raw track bytes, tracks position and flags id marks
// depends on mfmscan_pkg
module mfmscan_front #(
	parameter int TRACK_BYTES_MAX = mfmscan_pkg::TRACK_BYTES_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_fire,
	input  logic                            track_start,
	input  logic [7:0]                      track_byte,
	input  logic                            mark_clock,
	input  logic                            protect_bit,
	input  logic [mfmscan_pkg::POS_W:0]     len,
	output mfmscan_pkg::item_t              item
);
	import mfmscan_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(TRACK_BYTES_MAX - 1);

	logic [POS_W-1:0] pos_q;
	logic             prev_a1_q;
	logic [POS_W-1:0] p;
	logic             pa1;
	logic [POS_W+1:0] lim;

	always_comb begin
		p   = track_start ? '0 : pos_q;
		pa1 = track_start ? 1'b0 : prev_a1_q;
		lim = (POS_W+2)'(p) + (POS_W+2)'(GAP_BYTES - 1);
		item.rst     = track_start;
		item.b       = track_byte;
		item.mk      = mark_clock;
		item.pr      = protect_bit;
		item.prev_a1 = pa1;
		item.pos     = p;
		item.idmark  = pa1 && (track_byte == MARK_ID) && (p != '0) &&
			(lim < (POS_W+2)'(len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			prev_a1_q <= 1'b0;
		end else if (in_fire) begin
			pos_q     <= (p < POS_LAST) ? p + POS_W'(1) : p;
			prev_a1_q <= mark_clock && (track_byte == MARK_A1);
		end
	end

endmodule

>>> rtl/mfmscan_fifo.sv
// mfmscan_fifo: short queue of classified bytes between front and back
// depends on mfmscan_pkg
module mfmscan_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mfmscan_pkg::item_t wr_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output mfmscan_pkg::item_t rd_item
);
	import mfmscan_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	item_t         mem [FIFO_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;

	assign full    = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

>>> rtl/mfmscan_back.sv
// mfmscan_back: sector scan state machine, crc checks and result register
// depends on mfmscan_pkg
module mfmscan_back #(
	parameter int MAX_SECTORS      = mfmscan_pkg::MAX_SECTORS_DEF,
	parameter int DATA_MARK_WINDOW = mfmscan_pkg::DATA_MARK_WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  mfmscan_pkg::item_t          it,
	output logic                        pop,
	input  logic [mfmscan_pkg::POS_W:0] len,
	output logic                        out_valid,
	input  logic                        out_ready,
	output mfmscan_pkg::result_t        res
);
	import mfmscan_pkg::*;

	localparam int SF_W = $clog2(MAX_SECTORS + 1);
	localparam int WE_W = POS_W + 2;

	phase_t           ph_q, ph_eff, ph_d;
	logic [SF_W-1:0]  sf_q, sf_eff;
	logic [31:0]      hdr_q;
	logic [15:0]      crc_q;
	logic [7:0]       st_hi_q;
	logic [10:0]      fc_q;
	logic [WE_W-1:0]  we_q;
	logic             fl_idok_q, fl_data_q, fl_prot_q;
	logic [POS_W-1:0] ds_q;
	logic             out_valid_q;
	result_t          res_q;

	logic            hit, dam, dam_ok, stay, emit, go_data, start, hdr_done;
	logic            over, crc_match;
	logic [10:0]     dl;
	logic [WE_W-1:0] lenc, lenm;
	logic [6:0]      sf_ext;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		ph_eff    = it.rst ? PH_HUNT : ph_q;
		sf_eff    = it.rst ? '0 : sf_q;
		hit       = (it.pos == '0) || (WE_W'(it.pos) - WE_W'(1) >= we_q);
		dam       = it.prev_a1 && !it.mk;
		dam_ok    = (it.b == MARK_DEL) || (it.b == MARK_DATA);
		stay      = (fc_q == '0) || (!hit && !dam);
		dl        = BASE_LEN << hdr_q[1:0];
		crc_match = ({st_hi_q, it.b} == crc_q);
		over      = (32'(sf_eff) >= 32'(MAX_SECTORS));
		sf_ext    = 7'(sf_eff);
		lenc      = WE_W'(it.pos) - WE_W'(1) + WE_W'(GAP_BYTES + DATA_MARK_WINDOW);
		lenm      = WE_W'(len) - WE_W'(GAP_BYTES);
		emit      = 1'b0;
		go_data   = 1'b0;
		hdr_done  = 1'b0;
		case (ph_eff)
			PH_HEADER: hdr_done = (fc_q >= 11'd5);
			PH_WINDOW: begin
				go_data = (fc_q != '0) && !hit && dam && dam_ok;
				emit    = ((fc_q != '0) && (hit || (dam && !dam_ok))) || (stay && it.idmark);
			end
			PH_DATA:   emit = (fc_q > dl);
			default:   emit = 1'b0;
		endcase
		start = it.idmark && ((ph_eff == PH_HUNT) || ((ph_eff == PH_WINDOW) && emit));
	end

	always_comb begin
		if (start) begin
			ph_d = PH_HEADER;
		end else if (emit) begin
			ph_d = PH_HUNT;
		end else if (go_data) begin
			ph_d = PH_DATA;
		end else if (hdr_done) begin
			ph_d = PH_WINDOW;
		end else begin
			ph_d = ph_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_HUNT;
			sf_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ph_q <= ph_d;
				sf_q <= sf_eff + SF_W'(emit && !over);
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q     <= '0;
			crc_q     <= CRC_SEED;
			st_hi_q   <= '0;
			fc_q      <= '0;
			we_q      <= '0;
			fl_idok_q <= 1'b0;
			fl_data_q <= 1'b0;
			fl_prot_q <= 1'b0;
			ds_q      <= '0;
		end else if (pop) begin
			case (ph_eff)
				PH_HEADER: begin
					if (fc_q < 11'd4) begin
						crc_q <= crc_byte(crc_q, it.b);
						case (fc_q[1:0])
							2'd0:    hdr_q[31:24] <= it.b;
							2'd1:    hdr_q[23:16] <= it.b;
							2'd2:    hdr_q[15:8]  <= it.b;
							default: hdr_q[7:0]   <= it.b;
						endcase
					end else if (fc_q == 11'd4) begin
						st_hi_q <= it.b;
					end else if (crc_match) begin
						fl_idok_q <= 1'b1;
					end
					fc_q <= hdr_done ? '0 : fc_q + 11'd1;
				end
				PH_WINDOW: begin
					if (fc_q == '0) begin
						fc_q <= 11'd1;
					end else if (go_data) begin
						fl_data_q <= 1'b1;
						crc_q     <= crc_byte(CRC_SEED, it.b);
						fc_q      <= '0;
						ds_q      <= it.pos + POS_W'(1);
					end
				end
				PH_DATA: begin
					if (fc_q < dl) begin
						crc_q <= crc_byte(crc_q, it.b);
						if (it.pr) begin
							fl_prot_q <= 1'b1;
						end
					end else if (fc_q == dl) begin
						st_hi_q <= it.b;
					end
					fc_q <= fc_q + 11'd1;
				end
				default: begin
				end
			endcase
			if (start) begin
				hdr_q     <= '0;
				crc_q     <= crc_byte(CRC_SEED, MARK_ID);
				st_hi_q   <= '0;
				fc_q      <= '0;
				fl_idok_q <= 1'b0;
				fl_data_q <= 1'b0;
				fl_prot_q <= 1'b0;
				we_q      <= (lenm < lenc) ? lenm : lenc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q.slot <= over ? 5'd0 : sf_ext[4:0];
			res_q.cyl  <= hdr_q[31:24];
			res_q.head <= hdr_q[23:16];
			res_q.sec  <= hdr_q[15:8];
			res_q.size <= hdr_q[7:0];
			res_q.idok <= fl_idok_q;
			res_q.dat  <= fl_data_q;
			res_q.dok  <= fl_data_q && (ph_eff == PH_DATA) && crc_match;
			res_q.dpos <= fl_data_q ? 13'(ds_q) : 13'd0;
			res_q.dlen <= fl_data_q ? dl : 11'd0;
			res_q.prot <= fl_data_q && fl_prot_q;
			res_q.over <= over;
		end
	end

`ifndef SYNTHESIS
	a_sf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sf_q) <= 32'(MAX_SECTORS))
		else $error("sector count above limit");
	a_data_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DATA) |-> fl_data_q)
		else $error("data phase without data mark");
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_HEADER) |-> (fc_q <= 11'd5))
		else $error("header counter overrun");
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> out_valid_q)
		else $error("result lost");
`endif

endmodule
